[hdl/jsc_pkg.sv]
// Shared constants, codes, state type and helpers for the joystick scan conditioner.
package jsc_pkg;

  // Field widths
  localparam int unsigned AXIS_COUNT  = 4;
  localparam int unsigned AXIS_IDX_W  = 2;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned AXIS_W      = 8;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_DATA_W   = 64;
  localparam int unsigned OUT_DATA_W  = 40;
  localparam int unsigned EMA_SHIFT_DEF = 6;

  // Serial divider sizing
  localparam int unsigned DVD_W   = 24;  // dividend
  localparam int unsigned DVS_W   = 12;  // divisor and remainder
  localparam int unsigned QUO_W   = 12;  // quotient
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned Q_AXIS  = 8;   // quotient bits of an axis remap
  localparam int unsigned Q_PIN   = 12;  // quotient bits of the pin voltage
  localparam int unsigned Q_PCT   = 7;   // quotient bits of the percentage
  localparam int unsigned BAT_W   = 14;  // battery millivolts

  // Axis remap constants
  localparam int unsigned AXIS_MID  = 127;
  localparam int unsigned AXIS_HALF = 128;
  localparam int unsigned AXIS_FULL = 255;
  localparam int unsigned HALF_SH   = 7;   // multiply by AXIS_HALF

  // Battery constants
  localparam int unsigned VREF_MV   = 3300;
  localparam int unsigned ADC_FULL  = 4095;
  localparam int unsigned R_TOP     = 20000;
  localparam int unsigned R_LOWER   = 10000;
  localparam int unsigned BAT_RATIO = (R_TOP + R_LOWER) / R_LOWER;
  localparam int unsigned MIN_MV    = 6000;
  localparam int unsigned MAX_MV    = 8400;
  localparam int unsigned SPAN_MV   = MAX_MV - MIN_MV;
  localparam int unsigned PCT_FULL  = 100;
  localparam int unsigned HYST_PCT  = 2;

  // Work steps of one scan: four axis remaps, then the two battery divisions
  localparam logic [2:0] OP_LEFT_X  = 3'd0;
  localparam logic [2:0] OP_LEFT_Y  = 3'd1;
  localparam logic [2:0] OP_RIGHT_Y = 3'd2;
  localparam logic [2:0] OP_RIGHT_X = 3'd3;
  localparam logic [2:0] OP_PIN     = 3'd4;
  localparam logic [2:0] OP_PCT     = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_POST,
    ST_DONE
  } state_e;

  // Middle value of three
  function automatic logic [AXIS_W-1:0] mid3(input logic [AXIS_W-1:0] a,
                                             input logic [AXIS_W-1:0] b,
                                             input logic [AXIS_W-1:0] c);
    logic [AXIS_W-1:0] lo;
    logic [AXIS_W-1:0] hi;
    logic [AXIS_W-1:0] hc;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hc = (hi < c) ? hi : c;
    return (lo > hc) ? lo : hc;
  endfunction

endpackage

[hdl/joystick_scan_conditioner_unit.sv]
// Top level: median filter, centre remap and battery percentage for one ADC scan.
//
// One scan beat enters on s_axis (four 12-bit axis samples and a 12-bit battery
// sample in tdata) and one result beat leaves on m_axis (four 8-bit axes and the
// 7-bit battery percentage). Axis offsets are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; indexes 4..7 are dropped. The user must write them
// only while no scan is in flight; the block itself does not enforce this.
// Each scan runs through a bit-serial restoring divider shared by all six
// divisions: an axis remap skips the divider when the offset is zero or the
// sample sits on the centre, and the percentage skips it when clamped. A new
// scan is taken the cycle after the result is loaded into the output register,
// so a scan is not accepted before the previous one has finished its steps.
// The output register holds a result while m_axis_tready is low; the next scan
// may be accepted meanwhile and waits in its last step until the register frees.
// Reset clears the offsets, loads 127 into both history taps of every axis,
// and clears the battery average, its seed flag and the shown percentage.
module joystick_scan_conditioner_unit #(
  parameter int unsigned EMA_SHIFT = jsc_pkg::EMA_SHIFT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // left_x_sample, left_y_sample, right_y_sample, right_x_sample, battery_sample
  input  logic [jsc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // left_x_out, left_y_out, right_y_out, right_x_out, battery_pct
  output logic [jsc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_we_i,
  input  logic [jsc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [jsc_pkg::AXIS_W-1:0]           cfg_data_i
);

  localparam int unsigned ACC_W = jsc_pkg::SAMPLE_W + EMA_SHIFT;

  // State and datapath registers
  jsc_pkg::state_e state_q, state_d;
  logic [2:0]                       op_q, op_d;
  logic [jsc_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [jsc_pkg::DVS_W-1:0]        rem_q, rem_d;
  logic [jsc_pkg::DVD_W-1:0]        num_q, num_d;
  logic [jsc_pkg::QUO_W-1:0]        quo_q, quo_d;
  logic [jsc_pkg::DVS_W-1:0]        div_q, div_d;
  logic [jsc_pkg::AXIS_W-1:0]       base_q, base_d;
  logic [jsc_pkg::BAT_W-1:0]        bat_q, bat_d;
  logic [jsc_pkg::AXIS_W-1:0]       offset_q [jsc_pkg::AXIS_COUNT];
  logic [jsc_pkg::AXIS_W-1:0]       hist_new_q [jsc_pkg::AXIS_COUNT];
  logic [jsc_pkg::AXIS_W-1:0]       hist_new_d [jsc_pkg::AXIS_COUNT];
  logic [jsc_pkg::AXIS_W-1:0]       hist_old_q [jsc_pkg::AXIS_COUNT];
  logic [jsc_pkg::AXIS_W-1:0]       hist_old_d [jsc_pkg::AXIS_COUNT];
  logic [jsc_pkg::AXIS_W-1:0]       med_q [jsc_pkg::AXIS_COUNT];
  logic [jsc_pkg::AXIS_W-1:0]       med_d [jsc_pkg::AXIS_COUNT];
  logic [jsc_pkg::AXIS_W-1:0]       res_q [jsc_pkg::AXIS_COUNT];
  logic [jsc_pkg::AXIS_W-1:0]       res_d [jsc_pkg::AXIS_COUNT];
  logic [ACC_W-1:0]                 acc_q, acc_d;
  logic                             seeded_q, seeded_d;
  logic [jsc_pkg::PCT_W-1:0]        shown_q, shown_d;
  logic [jsc_pkg::OUT_DATA_W-1:0]   out_q, out_d;
  logic                             out_valid_q, out_valid_d;

  // Step setup values
  logic                             su_skip;
  logic [jsc_pkg::AXIS_W-1:0]       su_direct;
  logic [jsc_pkg::AXIS_W-1:0]       su_base;
  logic [jsc_pkg::DVS_W-1:0]        su_div;
  logic [jsc_pkg::DVS_W-1:0]        su_rem;
  logic [jsc_pkg::DVD_W-1:0]        su_num;
  logic [jsc_pkg::CNT_W-1:0]        su_cnt;
  logic [jsc_pkg::DVD_W-1:0]        dvd;
  logic [jsc_pkg::AXIS_IDX_W-1:0]   ax;
  logic [jsc_pkg::AXIS_W-1:0]       ax_v;
  logic [jsc_pkg::AXIS_W-1:0]       ax_off;
  logic [jsc_pkg::AXIS_W-1:0]       centre;
  logic [jsc_pkg::SAMPLE_W-1:0]     filt;

  // Divider step and misc
  logic [jsc_pkg::DVS_W:0]          trial;
  logic                             trial_ge;
  logic [jsc_pkg::AXIS_W-1:0]       post_val;
  logic [jsc_pkg::PCT_W:0]          pct_w;
  logic [jsc_pkg::PCT_W:0]          shown_w;
  logic                             in_fire;
  logic [jsc_pkg::SAMPLE_W-1:0]     batt_in;

  assign s_axis_tready = (state_q == jsc_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign batt_in = s_axis_tdata[jsc_pkg::AXIS_COUNT*jsc_pkg::SAMPLE_W +: jsc_pkg::SAMPLE_W];

  assign ax     = op_q[jsc_pkg::AXIS_IDX_W-1:0];
  assign ax_v   = med_q[ax];
  assign ax_off = offset_q[ax];
  assign centre = jsc_pkg::AXIS_W'(jsc_pkg::AXIS_MID) + ax_off;
  assign filt   = acc_q[EMA_SHIFT +: jsc_pkg::SAMPLE_W];

  // Set up the divider for the current step, or give its result directly
  always_comb begin
    dvd       = '0;
    su_skip   = 1'b0;
    su_direct = '0;
    su_base   = '0;
    su_div    = '0;
    su_rem    = '0;
    su_num    = '0;
    su_cnt    = '0;
    case (op_q)
      jsc_pkg::OP_LEFT_X, jsc_pkg::OP_LEFT_Y, jsc_pkg::OP_RIGHT_Y,
      jsc_pkg::OP_RIGHT_X: begin
        if (ax_off == '0) begin
          su_skip   = 1'b1;
          su_direct = ax_v;
        end else if (ax_v == centre) begin
          su_skip   = 1'b1;
          su_direct = jsc_pkg::AXIS_W'(jsc_pkg::AXIS_MID);
        end else if (ax_v < centre) begin
          dvd     = jsc_pkg::DVD_W'(ax_v) * jsc_pkg::DVD_W'(jsc_pkg::AXIS_MID);
          su_div  = jsc_pkg::DVS_W'(centre);
        end else begin
          dvd     = jsc_pkg::DVD_W'({ax_v - centre, {jsc_pkg::HALF_SH{1'b0}}});
          su_div  = jsc_pkg::DVS_W'(jsc_pkg::AXIS_W'(jsc_pkg::AXIS_FULL) - centre);
          su_base = jsc_pkg::AXIS_W'(jsc_pkg::AXIS_MID);
        end
        su_rem = jsc_pkg::DVS_W'(dvd >> jsc_pkg::Q_AXIS);
        su_num = dvd << (jsc_pkg::DVD_W - jsc_pkg::Q_AXIS);
        su_cnt = jsc_pkg::CNT_W'(jsc_pkg::Q_AXIS);
      end
      jsc_pkg::OP_PIN: begin
        dvd    = jsc_pkg::DVD_W'(filt) * jsc_pkg::DVD_W'(jsc_pkg::VREF_MV);
        su_div = jsc_pkg::DVS_W'(jsc_pkg::ADC_FULL);
        su_rem = jsc_pkg::DVS_W'(dvd >> jsc_pkg::Q_PIN);
        su_num = dvd << (jsc_pkg::DVD_W - jsc_pkg::Q_PIN);
        su_cnt = jsc_pkg::CNT_W'(jsc_pkg::Q_PIN);
      end
      jsc_pkg::OP_PCT: begin
        if (bat_q <= jsc_pkg::BAT_W'(jsc_pkg::MIN_MV)) begin
          su_skip   = 1'b1;
        end else if (bat_q >= jsc_pkg::BAT_W'(jsc_pkg::MAX_MV)) begin
          su_skip   = 1'b1;
          su_direct = jsc_pkg::AXIS_W'(jsc_pkg::PCT_FULL);
        end else begin
          dvd = jsc_pkg::DVD_W'(bat_q - jsc_pkg::BAT_W'(jsc_pkg::MIN_MV))
                * jsc_pkg::DVD_W'(jsc_pkg::PCT_FULL);
        end
        su_div = jsc_pkg::DVS_W'(jsc_pkg::SPAN_MV);
        su_rem = jsc_pkg::DVS_W'(dvd >> jsc_pkg::Q_PCT);
        su_num = dvd << (jsc_pkg::DVD_W - jsc_pkg::Q_PCT);
        su_cnt = jsc_pkg::CNT_W'(jsc_pkg::Q_PCT);
      end
      default: begin
        su_skip = 1'b1;
      end
    endcase
  end

  // One restoring-division bit per cycle
  assign trial    = {rem_q, num_q[jsc_pkg::DVD_W-1]};
  assign trial_ge = (trial >= {1'b0, div_q});
  assign post_val = base_q + quo_q[jsc_pkg::AXIS_W-1:0];
  assign pct_w    = {1'b0, quo_q[jsc_pkg::PCT_W-1:0]};
  assign shown_w  = {1'b0, shown_q};

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    num_d       = num_q;
    quo_d       = quo_q;
    div_d       = div_q;
    base_d      = base_q;
    bat_d       = bat_q;
    acc_d       = acc_q;
    seeded_d    = seeded_q;
    shown_d     = shown_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    hist_new_d  = hist_new_q;
    hist_old_d  = hist_old_q;
    med_d       = med_q;
    res_d       = res_q;

    case (state_q)
      jsc_pkg::ST_IDLE: begin
        if (in_fire) begin
          // Take the scan: median filter, history shift and battery average
          for (int k = 0; k < jsc_pkg::AXIS_COUNT; k++) begin
            med_d[k] = jsc_pkg::mid3(hist_old_q[k], hist_new_q[k],
                                     s_axis_tdata[k*jsc_pkg::SAMPLE_W + 4 +: jsc_pkg::AXIS_W]);
            hist_old_d[k] = hist_new_q[k];
            hist_new_d[k] = s_axis_tdata[k*jsc_pkg::SAMPLE_W + 4 +: jsc_pkg::AXIS_W];
          end
          if (seeded_q) begin
            acc_d = acc_q - (acc_q >> EMA_SHIFT) + ACC_W'(batt_in);
          end else begin
            acc_d = {batt_in, {EMA_SHIFT{1'b0}}};
          end
          seeded_d = 1'b1;
          op_d     = jsc_pkg::OP_LEFT_X;
          state_d  = jsc_pkg::ST_SETUP;
        end
      end
      jsc_pkg::ST_SETUP: begin
        div_d = su_div;
        rem_d = su_rem;
        num_d = su_num;
        cnt_d = su_cnt;
        quo_d = '0;
        if (su_skip) begin
          quo_d   = jsc_pkg::QUO_W'(su_direct);
          base_d  = '0;
          state_d = jsc_pkg::ST_POST;
        end else begin
          base_d  = su_base;
          state_d = jsc_pkg::ST_DIV;
        end
      end
      jsc_pkg::ST_DIV: begin
        rem_d = trial_ge ? jsc_pkg::DVS_W'(trial - {1'b0, div_q})
                         : jsc_pkg::DVS_W'(trial);
        num_d = num_q << 1;
        quo_d = {quo_q[jsc_pkg::QUO_W-2:0], trial_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == jsc_pkg::CNT_W'(1)) begin
          state_d = jsc_pkg::ST_POST;
        end
      end
      jsc_pkg::ST_POST: begin
        // Store the step result and advance
        case (op_q)
          jsc_pkg::OP_PIN: begin
            bat_d = jsc_pkg::BAT_W'(quo_q) * jsc_pkg::BAT_W'(jsc_pkg::BAT_RATIO);
          end
          jsc_pkg::OP_PCT: begin
            if ((pct_w >= shown_w + (jsc_pkg::PCT_W+1)'(jsc_pkg::HYST_PCT))
                || (pct_w + (jsc_pkg::PCT_W+1)'(jsc_pkg::HYST_PCT) <= shown_w)
                || (pct_w == '0)
                || (pct_w == (jsc_pkg::PCT_W+1)'(jsc_pkg::PCT_FULL))) begin
              shown_d = quo_q[jsc_pkg::PCT_W-1:0];
            end
          end
          default: begin
            res_d[ax] = post_val;
          end
        endcase
        if (op_q == jsc_pkg::OP_PCT) begin
          state_d = jsc_pkg::ST_DONE;
        end else begin
          op_d    = op_q + 1'b1;
          state_d = jsc_pkg::ST_SETUP;
        end
      end
      jsc_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_d       = {1'b0, shown_q, res_q[3], res_q[2], res_q[1], res_q[0]};
          out_valid_d = 1'b1;
          state_d     = jsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = jsc_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= jsc_pkg::OP_LEFT_X;
      cnt_q       <= '0;
      acc_q       <= '0;
      seeded_q    <= 1'b0;
      shown_q     <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < jsc_pkg::AXIS_COUNT; k++) begin
        offset_q[k]   <= '0;
        hist_new_q[k] <= jsc_pkg::AXIS_W'(jsc_pkg::AXIS_MID);
        hist_old_q[k] <= jsc_pkg::AXIS_W'(jsc_pkg::AXIS_MID);
      end
    end else begin
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      seeded_q    <= seeded_d;
      shown_q     <= shown_d;
      out_valid_q <= out_valid_d;
      hist_new_q  <= hist_new_d;
      hist_old_q  <= hist_old_d;
      // Offset writes; indexes past the last axis are dropped
      if (cfg_we_i && (cfg_idx_i < jsc_pkg::CFG_IDX_W'(jsc_pkg::AXIS_COUNT))) begin
        offset_q[cfg_idx_i[jsc_pkg::AXIS_IDX_W-1:0]] <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    div_q  <= div_d;
    base_q <= base_d;
    bat_q  <= bat_d;
    med_q  <= med_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // Checks
  a_shown_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shown_q <= jsc_pkg::PCT_W'(jsc_pkg::PCT_FULL))
    else $error("shown percentage above full scale");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jsc_pkg::ST_DIV) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jsc_pkg::ST_DIV) |-> (cnt_q != '0))
    else $error("divider running with zero count");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == jsc_pkg::ST_SETUP) && (op_q == jsc_pkg::OP_LEFT_X))
    else $error("accepted scan did not start at the first axis");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jsc_pkg::ST_DONE) && out_valid_q && !m_axis_tready |=>
      (state_q == jsc_pkg::ST_DONE))
    else $error("result left the sequencer while the output was stalled");

endmodule
